[design/go_to_point_steering_unit_assert.svh]
// Assertion macros for the go-to-point steering unit.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef GO_TO_POINT_STEERING_UNIT_ASSERT_SVH
`define GO_TO_POINT_STEERING_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define GTPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("gtps: assertion failed");
`define GTPS_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`else
`define GTPS_ASSERT(lbl, prop)
`define GTPS_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

[design/gtps_pkg.sv]
package gtps_pkg;

  localparam int COORD_BITS      = 12;
  localparam int ANGLE_FRAC_BITS = 12;
  localparam int CORDIC_STAGES   = 14;

  localparam int GAIN_W  = 16;
  localparam int TOP_W   = 8;
  localparam int RAD_W   = 12;
  localparam int HEAD_W  = 15;
  localparam int SPEED_W = 9;
  localparam int CFG_W   = 16;

  localparam int TAB_LEN = 20;
  localparam int NSTG    = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
  localparam int IDX_W   = $clog2(TAB_LEN);

  // coordinate difference, CORDIC vector and angle widths
  localparam int DW        = COORD_BITS + 1;
  localparam int PRE_SHIFT = 16;
  localparam int XW        = DW + PRE_SHIFT + 3;
  localparam int ZW        = ANGLE_FRAC_BITS + 4;

  // squared distance
  localparam int SQ_W  = 2 * COORD_BITS + 1;
  localparam int RSQ_W = 2 * RAD_W;
  localparam int CMP_W = (SQ_W > RSQ_W) ? SQ_W : RSQ_W;

  // heading error, product and speed sums
  localparam int EW    = ((ZW > HEAD_W) ? ZW : HEAD_W) + 1;
  localparam int WW    = EW + 2;
  localparam int ERR_W = ANGLE_FRAC_BITS + 3;
  localparam int PW    = ERR_W + GAIN_W + 1;
  localparam int FS    = ANGLE_FRAC_BITS + 8;
  localparam int SW    = ((PW > TOP_W + FS + 1) ? PW : TOP_W + FS + 1) + 2;

  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(256);
  localparam logic [TOP_W-1:0]  TOP_RST  = TOP_W'(128);
  localparam logic [RAD_W-1:0]  RAD_RST  = RAD_W'(16);
  localparam logic [RSQ_W-1:0]  RAD_SQ_RST = RSQ_W'(16 * 16);

  typedef enum logic [1:0] {
    CFG_STEER_GAIN    = 2'd0,
    CFG_TOP_SPEED     = 2'd1,
    CFG_ARRIVE_RADIUS = 2'd2
  } cfg_idx_e;

  // atan(2^-i) in Q30, then rounded into ANGLE_FRAC_BITS fraction bits
  localparam longint ATAN_Q30 [TAB_LEN] = '{
    64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158, 64'sd67021686,
    64'sd33543515,  64'sd16775850,  64'sd8388437,   64'sd4194282,   64'sd2097149,
    64'sd1048575,   64'sd524287,    64'sd262143,    64'sd131071,    64'sd65535,
    64'sd32767,     64'sd16383,     64'sd8191,      64'sd4095,      64'sd2047
  };
  localparam longint PI_Q30 = 64'sd3373259426;

  function automatic longint q30_round(longint v);
    return (v + (longint'(1) <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);
  endfunction

  localparam longint PI_ANG = q30_round(PI_Q30);
  localparam longint TWO_PI = 2 * PI_ANG;
  localparam longint ONE_RAD = longint'(1) <<< ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] PI_Z = ZW'(PI_ANG);

  // worst-case number of 2*pi corrections, done as a binary greedy reduction
  localparam longint ERR_MAX = (longint'(1) <<< (HEAD_W - 1)) + PI_ANG +
                               (longint'(2) <<< ANGLE_FRAC_BITS);
  localparam longint WRAP_N  = (ERR_MAX - PI_ANG + TWO_PI - 1) / TWO_PI;
  localparam int WRAP_STEPS  = (WRAP_N < 2) ? 1 : $clog2(WRAP_N + 1);

  function automatic logic signed [ZW-1:0] atan_angle(int i);
    return ZW'(q30_round(ATAN_Q30[i]));
  endfunction

  // word handed along the CORDIC chain
  typedef struct packed {
    logic signed [XW-1:0]     x;
    logic signed [XW-1:0]     y;
    logic signed [ZW-1:0]     z;
    logic signed [HEAD_W-1:0] head;
    logic                     zero;
    logic                     arrived;
  } cdc_word_t;

endpackage

[design/gtps_front.sv]
module gtps_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gtps_pkg::COORD_BITS-1:0] robot_x_i,
  input  logic [gtps_pkg::COORD_BITS-1:0] robot_y_i,
  input  logic signed [gtps_pkg::HEAD_W-1:0] robot_heading_i,
  input  logic [gtps_pkg::COORD_BITS-1:0] goal_x_i,
  input  logic [gtps_pkg::COORD_BITS-1:0] goal_y_i,
  input  logic [gtps_pkg::RSQ_W-1:0]    rad_sq_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output gtps_pkg::cdc_word_t           word_o
);
  import gtps_pkg::*;

  // stage A: offsets
  logic                     a_vld_q;
  logic signed [DW-1:0]     a_dx_q, a_dy_q;
  logic signed [HEAD_W-1:0] a_head_q;
  // stage B: squares and quadrant fold
  logic                       b_vld_q;
  logic [2*COORD_BITS-1:0]    b_dx2_q, b_dy2_q;
  logic [2*COORD_BITS-1:0]    b_dx2_d, b_dy2_d;
  cdc_word_t                  b_word_q, b_word_d;
  // stage C: arrival test
  logic      c_vld_q;
  cdc_word_t c_word_q, c_word_d;

  logic a_rdy, b_rdy, c_rdy;
  logic signed [2*DW-1:0] dx2_full, dy2_full;
  logic signed [XW-1:0]   x0, y0;
  logic [SQ_W-1:0]        dist_sq;

  assign c_rdy      = ~c_vld_q | ready_i;
  assign b_rdy      = ~b_vld_q | c_rdy;
  assign a_rdy      = ~a_vld_q | b_rdy;
  assign in_ready_o = a_rdy;

  always_comb begin
    dx2_full = (2*DW)'(a_dx_q) * (2*DW)'(a_dx_q);
    dy2_full = (2*DW)'(a_dy_q) * (2*DW)'(a_dy_q);
    b_dx2_d  = dx2_full[2*COORD_BITS-1:0];
    b_dy2_d  = dy2_full[2*COORD_BITS-1:0];
    x0 = {{(XW-DW-PRE_SHIFT){a_dx_q[DW-1]}}, a_dx_q, {PRE_SHIFT{1'b0}}};
    y0 = {{(XW-DW-PRE_SHIFT){a_dy_q[DW-1]}}, a_dy_q, {PRE_SHIFT{1'b0}}};
    b_word_d.head    = a_head_q;
    b_word_d.zero    = (a_dx_q == '0) && (a_dy_q == '0);
    b_word_d.arrived = 1'b0;
    if (a_dx_q[DW-1]) begin
      // left half plane: rotate by pi first
      b_word_d.x = -x0;
      b_word_d.y = -y0;
      b_word_d.z = a_dy_q[DW-1] ? -PI_Z : PI_Z;
    end else begin
      b_word_d.x = x0;
      b_word_d.y = y0;
      b_word_d.z = '0;
    end
  end

  always_comb begin
    dist_sq          = SQ_W'(b_dx2_q) + SQ_W'(b_dy2_q);
    c_word_d         = b_word_q;
    c_word_d.arrived = CMP_W'(dist_sq) < CMP_W'(rad_sq_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      if (a_rdy) a_vld_q <= in_valid_i;
      if (b_rdy) b_vld_q <= a_vld_q;
      if (c_rdy) c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && in_valid_i) begin
      a_dx_q   <= $signed({1'b0, goal_x_i}) - $signed({1'b0, robot_x_i});
      a_dy_q   <= $signed({1'b0, goal_y_i}) - $signed({1'b0, robot_y_i});
      a_head_q <= robot_heading_i;
    end
    if (b_rdy && a_vld_q) begin
      b_dx2_q  <= b_dx2_d;
      b_dy2_q  <= b_dy2_d;
      b_word_q <= b_word_d;
    end
    if (c_rdy && b_vld_q) c_word_q <= c_word_d;
  end

  assign valid_o = c_vld_q;
  assign word_o  = c_word_q;

endmodule

[design/gtps_cordic_cell.sv]
module gtps_cordic_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [gtps_pkg::IDX_W-1:0]        idx_i,
  input  logic signed [gtps_pkg::ZW-1:0]    angle_i,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  gtps_pkg::cdc_word_t               word_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output gtps_pkg::cdc_word_t               word_o
);
  import gtps_pkg::*;

  logic                 vld_q;
  cdc_word_t            word_q, word_d;
  logic signed [XW-1:0] xs, ys;

  assign ready_o = ~vld_q | ready_i;

  // one vectoring micro-rotation, driving y toward zero
  always_comb begin
    xs     = word_i.x >>> idx_i;
    ys     = word_i.y >>> idx_i;
    word_d = word_i;
    if (!word_i.y[XW-1]) begin
      word_d.x = word_i.x + ys;
      word_d.y = word_i.y - xs;
      word_d.z = word_i.z + angle_i;
    end else begin
      word_d.x = word_i.x - ys;
      word_d.y = word_i.y + xs;
      word_d.z = word_i.z - angle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) word_q <= word_d;
  end

  assign valid_o = vld_q;
  assign word_o  = word_q;

endmodule

[design/gtps_back.sv]
module gtps_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  gtps_pkg::cdc_word_t                 word_i,
  input  logic [gtps_pkg::GAIN_W-1:0]         steer_gain_i,
  input  logic [gtps_pkg::TOP_W-1:0]          top_speed_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [gtps_pkg::SPEED_W-1:0] left_speed_o,
  output logic signed [gtps_pkg::SPEED_W-1:0] right_speed_o,
  output logic                                arrived_o,
  output logic                                spinning_o
);
  import gtps_pkg::*;

  // stage W: heading error, wrapped
  logic                    w_vld_q, w_spin_q, w_arr_q;
  logic signed [ERR_W-1:0] w_err_q;
  logic signed [WW-1:0]    err_raw, err_wr, err_try;
  logic                    w_spin_d;
  // stage M: error times gain
  logic                 m_vld_q, m_spin_q, m_arr_q;
  logic signed [PW-1:0] m_prod_q, m_prod_d;
  // stage O: output word
  logic                      o_vld_q;
  logic signed [SPEED_W-1:0] o_left_q, o_right_q, o_left_d, o_right_d;
  logic                      o_arr_q, o_spin_q;

  logic w_rdy, m_rdy, o_rdy;
  logic signed [SW-1:0] base, prod_ext;
  logic signed [SW-1:0] top_ext;

  localparam logic signed [WW-1:0] PI_W  = WW'(PI_ANG);
  localparam logic signed [WW-1:0] ONE_W = WW'(ONE_RAD);

  function automatic logic signed [SPEED_W-1:0] round_clamp(logic signed [SW-1:0] v,
                                                             logic signed [SW-1:0] tp);
    logic signed [SW-1:0] r;
    r = (v + (SW'(1) <<< (FS - 1))) >>> FS;
    if (r > tp) r = tp;
    else if (r < -tp) r = -tp;
    return SPEED_W'(r);
  endfunction

  assign o_rdy   = ~o_vld_q | ~out_stall_i;
  assign m_rdy   = ~m_vld_q | o_rdy;
  assign w_rdy   = ~w_vld_q | m_rdy;
  assign ready_o = w_rdy;

  // wrap into [-pi, pi] by greedy multiples of 2*pi
  always_comb begin
    err_raw = (word_i.zero ? WW'(0) : WW'(word_i.z)) - WW'(word_i.head);
    err_wr  = err_raw;
    err_try = err_raw;
    if (err_raw > PI_W) begin
      for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
        err_try = err_wr - WW'(TWO_PI <<< k);
        if (err_try > -PI_W) err_wr = err_try;
      end
    end else if (err_raw < -PI_W) begin
      for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
        err_try = err_wr + WW'(TWO_PI <<< k);
        if (err_try < PI_W) err_wr = err_try;
      end
    end
    w_spin_d = (err_wr > ONE_W) || (err_wr < -ONE_W);
  end

  assign m_prod_d = PW'(w_err_q) * PW'($signed({1'b0, steer_gain_i}));

  always_comb begin
    top_ext  = SW'($signed({1'b0, top_speed_i}));
    base     = top_ext <<< FS;
    prod_ext = SW'(m_prod_q);
    if (m_arr_q) begin
      o_left_d  = '0;
      o_right_d = '0;
    end else if (m_spin_q) begin
      o_left_d  = round_clamp(prod_ext, top_ext);
      o_right_d = -o_left_d;
    end else begin
      o_left_d  = round_clamp(base - prod_ext, top_ext);
      o_right_d = round_clamp(base + prod_ext, top_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (w_rdy) w_vld_q <= valid_i;
      if (m_rdy) m_vld_q <= w_vld_q;
      if (o_rdy) o_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_rdy && valid_i) begin
      w_err_q  <= ERR_W'(err_wr);
      w_spin_q <= w_spin_d;
      w_arr_q  <= word_i.arrived;
    end
    if (m_rdy && w_vld_q) begin
      m_prod_q <= m_prod_d;
      m_spin_q <= w_spin_q & ~w_arr_q;
      m_arr_q  <= w_arr_q;
    end
    if (o_rdy && m_vld_q) begin
      o_left_q  <= o_left_d;
      o_right_q <= o_right_d;
      o_arr_q   <= m_arr_q;
      o_spin_q  <= m_spin_q;
    end
  end

  assign out_valid_o   = o_vld_q;
  assign left_speed_o  = o_left_q;
  assign right_speed_o = o_right_q;
  assign arrived_o     = o_arr_q;
  assign spinning_o    = o_spin_q;

endmodule

[design/go_to_point_steering_unit.sv]
// Go-to-point steering for a differential-drive robot. Each input word is one
// pose sample (robot x/y in pixels, heading in signed Q3.12 radians) plus a
// target point; each output word is a left/right wheel command pair with the
// arrived and spinning flags. The unit takes one word per clock while
// in_stall_o is low and holds up to 20 words in flight. Between input accept
// and output valid a word passes through registers for offsets, squares and
// the arrival test, one register per CORDIC cell (14 CORDIC stages), then the
// heading wrap, gain multiply and output registers. Stall on the output backs up
// stage by stage, so empty stages still fill while the output waits.
// Configuration (steer_gain, top_speed, arrive_radius) is written through
// cfg_we_i/cfg_idx_i/cfg_data_i and must only change while no word is in
// flight.
`include "go_to_point_steering_unit_assert.svh"

module go_to_point_steering_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [gtps_pkg::CFG_W-1:0]          cfg_data_i,
  // pose word in
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [gtps_pkg::COORD_BITS-1:0]     robot_x_i,
  input  logic [gtps_pkg::COORD_BITS-1:0]     robot_y_i,
  input  logic signed [gtps_pkg::HEAD_W-1:0]  robot_heading_i,
  input  logic [gtps_pkg::COORD_BITS-1:0]     goal_x_i,
  input  logic [gtps_pkg::COORD_BITS-1:0]     goal_y_i,
  // wheel command word out
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [gtps_pkg::SPEED_W-1:0] left_speed_o,
  output logic signed [gtps_pkg::SPEED_W-1:0] right_speed_o,
  output logic                                arrived_o,
  output logic                                spinning_o
);
  import gtps_pkg::*;

  logic [GAIN_W-1:0] steer_gain_q;
  logic [TOP_W-1:0]  top_speed_q;
  logic [RAD_W-1:0]  arrive_radius_q;
  logic [RSQ_W-1:0]  rad_sq_q;

  // chain nodes: node 0 is the front output, node NSTG feeds the back end
  logic      chain_vld [NSTG+1];
  logic      chain_rdy [NSTG+1];
  cdc_word_t chain_word [NSTG+1];
  logic      front_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steer_gain_q    <= GAIN_RST;
      top_speed_q     <= TOP_RST;
      arrive_radius_q <= RAD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_STEER_GAIN:    steer_gain_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_TOP_SPEED:     top_speed_q     <= cfg_data_i[TOP_W-1:0];
        CFG_ARRIVE_RADIUS: arrive_radius_q <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // squared radius, refreshed every cycle from the register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_sq_q <= RAD_SQ_RST;
    end else begin
      rad_sq_q <= RSQ_W'(arrive_radius_q) * RSQ_W'(arrive_radius_q);
    end
  end

  gtps_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (front_rdy),
    .robot_x_i       (robot_x_i),
    .robot_y_i       (robot_y_i),
    .robot_heading_i (robot_heading_i),
    .goal_x_i        (goal_x_i),
    .goal_y_i        (goal_y_i),
    .rad_sq_i        (rad_sq_q),
    .valid_o         (chain_vld[0]),
    .ready_i         (chain_rdy[0]),
    .word_o          (chain_word[0])
  );

  assign in_stall_o = ~front_rdy;

  // vectoring CORDIC, one micro-rotation per cell
  for (genvar g = 0; g < NSTG; g++) begin : g_cell
    gtps_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(g)),
      .angle_i (atan_angle(g)),
      .valid_i (chain_vld[g]),
      .ready_o (chain_rdy[g]),
      .word_i  (chain_word[g]),
      .valid_o (chain_vld[g+1]),
      .ready_i (chain_rdy[g+1]),
      .word_o  (chain_word[g+1])
    );
  end

  gtps_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (chain_vld[NSTG]),
    .ready_o       (chain_rdy[NSTG]),
    .word_i        (chain_word[NSTG]),
    .steer_gain_i  (steer_gain_q),
    .top_speed_i   (top_speed_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .left_speed_o  (left_speed_o),
    .right_speed_o (right_speed_o),
    .arrived_o     (arrived_o),
    .spinning_o    (spinning_o)
  );

  // an arrived word stops both wheels and is never a spin
  `GTPS_ASSERT_MSG(a_arrived_stops, out_valid_o && arrived_o |-> left_speed_o == '0 && right_speed_o == '0 && !spinning_o, "gtps: arrived word with wheel motion")
  // spinning in place drives the wheels in opposite directions
  `GTPS_ASSERT(a_spin_opposite, out_valid_o && spinning_o |-> right_speed_o == -left_speed_o)
  // input side can only be held off when the output side is stalled
  `GTPS_ASSERT_MSG(a_stall_source, in_stall_o |-> out_stall_i, "gtps: input stalled without output stall")

endmodule
